// ----- rtl/ils_pkg.sv -----
`timescale 1ns / 1ps

package ils_pkg;

  localparam int REQ_W = 3;
  localparam int POS_W = 6;
  localparam int ST_W  = 2;

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_ERR  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic finish_early;
    logic start_shift;
    logic shift_run;
    logic finish_shift;
  } ils_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early;
    logic shift_done;
  } ils_stat_t;

endpackage

// ----- rtl/indexed_list_store.sv -----
`timescale 1ns / 1ps

// Ordered list of CAPACITY words held in a single-port-pair RAM.
// Input: a word (request type, position, data) is taken on the rising edge at
// which start is high and busy is low. Request types are append, insert at a
// position, read, remove at a position and clear; for read and remove a negative
// position counts back from the end of the list, and an insert rejects it.
// Output: every request gives exactly one result word on out_*, shown for one
// cycle with out_valid high. The receiver cannot hold it off.
// Append, clear and rejected requests finish right after the decision step; a
// read fetches its entry and an insert or remove moves the entries behind the
// position in a shift phase first. Busy drops in the strobe cycle, so the next
// word may be taken at the edge that ends it; one item thus occupies the block
// until its result is shown. Shifting is done one entry a cycle through the
// RAM's single read and write port. Reset empties the list at once; no clearing
// pass is needed, as entries are only read after they were written.
module indexed_list_store #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ils_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [ils_pkg::POS_W-1:0] in_position,
  input  logic [WORD_BITS-1:0]             in_word_in,
  output logic                             out_valid,
  output logic [WORD_BITS-1:0]             out_word_out,
  output logic [$clog2(CAPACITY+1)-1:0]    out_count_out,
  output logic [ils_pkg::ST_W-1:0]         out_status
);

  import ils_pkg::*;

  ils_cmd_t  cmd;
  ils_stat_t stat;

  ils_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ils_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_req_type),
    .in_position   (in_position),
    .in_word_in    (in_word_in),
    .out_valid     (out_valid),
    .out_word_out  (out_word_out),
    .out_count_out (out_count_out),
    .out_status    (out_status)
  );

endmodule

// ----- rtl/ils_ram.sv -----
`timescale 1ns / 1ps

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ils_ctrl.sv -----
`timescale 1ns / 1ps

module ils_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ils_pkg::ils_stat_t stat,
  output ils_pkg::ils_cmd_t  cmd
);

  import ils_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.early) begin
          cmd.finish_early = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cmd.start_shift = 1'b1;
          state_nxt       = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.finish_shift = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cmd.shift_run = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_capture_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DECIDE)
    else $error("accepted word did not move to the decision step");

  a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish_early || cmd.finish_shift) |=> !busy)
    else $error("block still busy after its result");

endmodule

// ----- rtl/ils_datapath.sv -----
`timescale 1ns / 1ps

module ils_datapath #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ils_pkg::ils_cmd_t                   cmd,
  output ils_pkg::ils_stat_t                  stat,
  input  logic [ils_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [ils_pkg::POS_W-1:0]    in_position,
  input  logic [WORD_BITS-1:0]                in_word_in,
  output logic                                out_valid,
  output logic [WORD_BITS-1:0]                out_word_out,
  output logic [$clog2(CAPACITY+1)-1:0]       out_count_out,
  output logic [ils_pkg::ST_W-1:0]            out_status
);

  import ils_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int SW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  logic [REQ_W-1:0]     req_r;
  logic [POS_W-1:0]     pos_r;
  logic [WORD_BITS-1:0] word_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [IDX_W-1:0]     ptr_r;
  logic [IDX_W-1:0]     dst_r;
  logic [CNT_W-1:0]     rem_r;
  logic                 pend_r;
  logic                 grab_r;
  logic                 up_r;
  logic [WORD_BITS-1:0] res_word_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_word_r;
  logic [CNT_W-1:0]     out_count_r;
  logic [ST_W-1:0]      out_status_r;

  logic signed [SW-1:0] pos_s;
  logic signed [SW-1:0] n_s;
  logic signed [SW-1:0] adj_s;
  logic signed [SW-1:0] idx_s;
  logic                 neg;
  logic                 full;
  logic                 ins_err;
  logic                 acc_err;
  logic [CNT_W-1:0]     idx_c;
  logic [IDX_W-1:0]     idx_a;
  logic [CNT_W-1:0]     cnt_m1;
  logic [ST_W-1:0]      st;
  logic                 early;
  logic [CNT_W-1:0]     rem_start;
  logic [IDX_W-1:0]     ptr_start;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // For read and remove, a negative position counts back from the end of the list; insert rejects it.
  always_comb begin
    neg     = pos_r[POS_W-1];
    pos_s   = signed'({{(SW-POS_W){pos_r[POS_W-1]}}, pos_r});
    n_s     = signed'({{(SW-CNT_W){1'b0}}, count_r});
    adj_s   = pos_s + n_s;
    idx_s   = neg ? adj_s : pos_s;
    idx_c   = idx_s[CNT_W-1:0];
    idx_a   = idx_s[IDX_W-1:0];
    cnt_m1  = count_r - CNT_W'(1);
    full    = (count_r >= CNT_W'(CAPACITY));
    ins_err = neg || (pos_s > n_s);
    acc_err = (count_r == '0) || (pos_s >= n_s) || (neg && adj_s[SW-1]);
  end

  always_comb begin
    st        = ST_OK;
    early     = 1'b1;
    rem_start = '0;
    ptr_start = idx_a;
    unique case (req_r) inside
      REQ_APPEND: begin
        st = full ? ST_FULL : ST_OK;
      end
      REQ_INSERT: begin
        st        = ins_err ? ST_ERR : (full ? ST_FULL : ST_OK);
        early     = (st != ST_OK);
        rem_start = count_r - idx_c;
        ptr_start = cnt_m1[IDX_W-1:0];
      end
      REQ_READ, REQ_REMOVE: begin
        st    = acc_err ? ST_ERR : ST_OK;
        early = acc_err;
        if (req_r == REQ_REMOVE) begin
          rem_start = count_r - idx_c - CNT_W'(1);
          ptr_start = idx_a + IDX_W'(1);
        end
      end
      REQ_CLEAR: begin
        st = ST_OK;
      end
      default: begin
        st = ST_ERR;
      end
    endcase
  end

  assign stat.early      = early;
  assign stat.shift_done = (rem_r == '0) && !pend_r && !grab_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish_early) begin
      if (req_r == REQ_APPEND && st == ST_OK) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (req_r == REQ_CLEAR) begin
        count_nxt = '0;
      end
    end
    if (cmd.finish_shift) begin
      if (req_r == REQ_INSERT) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (req_r == REQ_REMOVE) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // Each move writes in the cycle after its read, so the write pointer trails the read pointer.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst_r;
    ram_wdata = ram_rdata;
    if (cmd.shift_run && pend_r) begin
      ram_we = 1'b1;
    end else if (cmd.finish_early && req_r == REQ_APPEND && st == ST_OK) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[IDX_W-1:0];
      ram_wdata = word_r;
    end else if (cmd.finish_shift && req_r == REQ_INSERT) begin
      ram_we    = 1'b1;
      ram_waddr = idx_a;
      ram_wdata = word_r;
    end
    ram_re    = (cmd.start_shift && req_r != REQ_INSERT) ||
                (cmd.shift_run && rem_r != '0);
    ram_raddr = cmd.start_shift ? idx_a : ptr_r;
  end

  ils_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end
    if (cmd.start_shift) begin
      ptr_r <= ptr_start;
      up_r  <= (req_r == REQ_REMOVE);
    end else if (cmd.shift_run && rem_r != '0) begin
      ptr_r <= up_r ? ptr_r + IDX_W'(1) : ptr_r - IDX_W'(1);
      dst_r <= up_r ? ptr_r - IDX_W'(1) : ptr_r + IDX_W'(1);
    end
    if (cmd.shift_run && grab_r) begin
      res_word_r <= ram_rdata;
    end
    if (cmd.finish_early || cmd.finish_shift) begin
      out_word_r   <= (cmd.finish_shift && req_r != REQ_INSERT) ? res_word_r : '0;
      out_count_r  <= count_nxt;
      out_status_r <= cmd.finish_early ? st : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      grab_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish_early || cmd.finish_shift;
      if (cmd.start_shift) begin
        rem_r  <= rem_start;
        pend_r <= 1'b0;
        grab_r <= (req_r != REQ_INSERT);
      end else if (cmd.shift_run) begin
        grab_r <= 1'b0;
        pend_r <= (rem_r != '0);
        if (rem_r != '0) begin
          rem_r <= rem_r - CNT_W'(1);
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word_out  = out_word_r;
  assign out_count_out = out_count_r;
  assign out_status    = out_status_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> cmd.shift_run)
    else $error("pending move dropped before it was written");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("two result strobes in a row");

endmodule
